/* rtl/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared codes, result types and defaults for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int CLT_MAX_ARGS_DEF = 16;
    localparam int CLT_RESULTS      = 3;

    localparam logic [4:0] CLT_CFG_RESET = 5'd16;

    // parse modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_PLAIN   = 3'd1;
    localparam logic [2:0] MODE_QUOTED  = 3'd2;
    localparam logic [2:0] MODE_VAR     = 3'd3;
    localparam logic [2:0] MODE_DISCARD = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_CMD_END   = 2'd2;

    // command end reasons
    localparam logic [1:0] WHY_EOL   = 2'd0;
    localparam logic [1:0] WHY_SEP   = 2'd1;
    localparam logic [1:0] WHY_LIMIT = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOLR  = 8'h24;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [4:0] arg_index;
        logic [1:0] end_reason;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]                    n;
        t_result [CLT_RESULTS-1:0]     res;
        logic [2:0]                    next_mode;
        logic [4:0]                    next_count;
    } t_step;

endpackage

/* rtl/clt_step.sv */
// ----------------------------------------------------------------------------
// clt_step
// Decodes one character against the parse state: up to three results and
// the next state.
// ----------------------------------------------------------------------------
module clt_step
    import clt_pkg::*;
(
    input  logic [2:0] i_mode,
    input  logic [4:0] i_count,
    input  logic [4:0] i_limit,
    input  logic [7:0] i_ch,
    output t_step      o_step
);

    logic       blank;
    logic       is_nul;
    logic       is_semi;
    logic       emit_byte;
    logic [7:0] byte_val;
    logic       tok_end;
    logic       tok_quote;
    logic       cmd_end;
    logic [1:0] cmd_why;
    logic [4:0] cmd_idx;
    logic [4:0] cnt1;
    logic [1:0] k;

    assign blank   = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
    assign is_nul  = (i_ch == CH_NUL);
    assign is_semi = (i_ch == CH_SEMI);
    assign cnt1    = i_count + 5'd1;

    always_comb begin
        emit_byte          = 1'b0;
        byte_val           = i_ch;
        tok_end            = 1'b0;
        tok_quote          = 1'b0;
        cmd_end            = 1'b0;
        cmd_why            = WHY_EOL;
        cmd_idx            = i_count;
        o_step             = '0;
        o_step.next_mode   = i_mode;
        o_step.next_count  = i_count;

        unique case (i_mode)
            MODE_PLAIN: begin
                if (is_nul || blank || is_semi) tok_end = 1'b1;
                else                            emit_byte = 1'b1;
            end
            MODE_QUOTED: begin
                if (is_nul || i_ch == CH_QUOTE) begin
                    tok_end   = 1'b1;
                    tok_quote = (i_ch == CH_QUOTE);
                end else begin
                    emit_byte = 1'b1;
                end
            end
            MODE_VAR: begin
                if (is_nul || blank || is_semi) begin
                    emit_byte = 1'b1;
                    byte_val  = CH_ZERO;
                    tok_end   = 1'b1;
                end
            end
            MODE_DISCARD: begin
                if (is_nul) o_step.next_mode = MODE_BETWEEN;
            end
            default: begin
                priority if (is_nul) begin
                    cmd_end = 1'b1;
                    cmd_why = WHY_EOL;
                end else if (blank) begin
                    o_step.next_mode = MODE_BETWEEN;
                end else if (is_semi) begin
                    cmd_end = 1'b1;
                    cmd_why = WHY_SEP;
                end else if (i_ch == CH_QUOTE) begin
                    o_step.next_mode = MODE_QUOTED;
                end else if (i_ch == CH_DOLR) begin
                    o_step.next_mode = MODE_VAR;
                end else begin
                    o_step.next_mode = MODE_PLAIN;
                    emit_byte        = 1'b1;
                end
            end
        endcase

        // follow-up after a token end
        if (tok_end) begin
            cmd_idx           = cnt1;
            o_step.next_count = cnt1;
            priority if (is_nul) begin
                cmd_end = 1'b1;
                cmd_why = WHY_EOL;
            end else if (cnt1 >= i_limit) begin
                cmd_end = 1'b1;
                cmd_why = WHY_LIMIT;
            end else if (!tok_quote && is_semi) begin
                cmd_end = 1'b1;
                cmd_why = WHY_SEP;
            end else begin
                o_step.next_mode = MODE_BETWEEN;
            end
        end

        if (cmd_end) begin
            o_step.next_count = 5'd0;
            o_step.next_mode  = (cmd_why == WHY_LIMIT) ? MODE_DISCARD : MODE_BETWEEN;
        end

        // pack the results in order
        k = 2'd0;
        if (emit_byte) begin
            o_step.res[k] = '{kind: KIND_BYTE, out_byte: byte_val, arg_index: i_count,
                              end_reason: WHY_EOL, last: 1'b0};
            k = k + 2'd1;
        end
        if (tok_end) begin
            o_step.res[k] = '{kind: KIND_TOKEN_END, out_byte: 8'd0, arg_index: i_count,
                              end_reason: WHY_EOL, last: 1'b0};
            k = k + 2'd1;
        end
        if (cmd_end) begin
            o_step.res[k] = '{kind: KIND_CMD_END, out_byte: 8'd0, arg_index: cmd_idx,
                              end_reason: cmd_why, last: 1'b0};
            k = k + 2'd1;
        end
        o_step.n = k;
        for (int i = 0; i < CLT_RESULTS; i++) begin
            o_step.res[i].last = (2'(i + 1) == k);
        end
    end

endmodule

/* rtl/clt_out_buf.sv */
// ----------------------------------------------------------------------------
// clt_out_buf
// Result register: holds the results of one character and shifts them out
// one beat at a time.
// ----------------------------------------------------------------------------
module clt_out_buf
    import clt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_step   i_step,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res,
    output logic [1:0] o_n
);

    t_result [CLT_RESULTS-1:0] r_res;
    logic [1:0]                r_n;
    logic                      take;

    assign o_valid = (r_n != 2'd0);
    assign take    = o_valid && !i_stall;
    assign o_free  = !o_valid || (take && r_n == 2'd1);
    assign o_res   = r_res[0];
    assign o_n     = r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 2'd0;
        end else if (i_load) begin
            r_n <= i_step.n;
        end else if (take) begin
            r_n <= r_n - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_step.res;
        end else if (take) begin
            for (int i = 0; i < CLT_RESULTS - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

endmodule

/* rtl/command_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a stream of command-line characters into token bytes, token ends
// and command ends with argument counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel : i_valid / i_ch, stalled by o_stall. One character a beat.
//   Output channel: o_valid / o_kind, o_out_byte, o_arg_index, o_end_reason,
//                   o_last, stalled by i_stall. o_last flags the final result
//                   beat of a character; a character gives zero to three beats.
//   Config        : i_max_args_we / i_max_args write the argument limit
//                   (clamped to 1..min(MAX_ARGS, 31)); write only while idle.
// Path: an accepted character waits in the input register, is decoded there
//   and moves its results into the result register once that register is
//   free, so a stalled output can hold it in the input register.
// Throughput: one character per cycle while each gives at most one result
//   and the output is not stalled; a character with k results holds the
//   result register until its k beats are taken, and the input register
//   stalls the input meanwhile. Characters with no result (blanks, quotes,
//   variable names, discarded text) still pass at one per cycle unless stalled.
// Reset: parse state goes between fields, argument count to zero, limit to
//   16, both registers empty.
// Stall: a stalled output holds its beat; the input register fills and then
//   o_stall rises, nothing is dropped.
// ----------------------------------------------------------------------------
module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int MAX_ARGS = CLT_MAX_ARGS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character input
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    output logic       o_stall,
    // result output
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [4:0] o_arg_index,
    output logic [1:0] o_end_reason,
    output logic       o_last,
    input  logic       i_stall,
    // configuration
    input  logic       i_max_args_we,
    input  logic [4:0] i_max_args
);

    // the argument count is five bits, so the limit never goes past 31
    localparam int LIM_CAP = (MAX_ARGS > 31) ? 31 : MAX_ARGS;

    logic [4:0] r_max_args;
    logic [4:0] limit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       in_acc;
    logic       consume;

    // parse state
    logic [2:0] r_mode;
    logic [4:0] r_count;

    t_step      step;
    t_result    cur;
    logic       buf_free;
    logic [1:0] buf_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args <= CLT_CFG_RESET;
        end else if (i_max_args_we) begin
            r_max_args <= i_max_args;
        end
    end

    always_comb begin
        if (r_max_args == 5'd0)               limit = 5'd1;
        else if (r_max_args > 5'(LIM_CAP))    limit = 5'(LIM_CAP);
        else                                  limit = r_max_args;
    end

    // the held character moves on once the result register can take its beats
    assign consume = r_in_valid && buf_free;
    assign o_stall = r_in_valid && !buf_free;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BETWEEN;
            r_count <= 5'd0;
        end else if (consume) begin
            r_mode  <= step.next_mode;
            r_count <= step.next_count;
        end
    end

    clt_step u_step (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_limit (limit),
        .i_ch    (r_ch),
        .o_step  (step)
    );

    clt_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_step  (step),
        .i_stall (i_stall),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .o_res   (cur),
        .o_n     (buf_n)
    );

    assign o_kind       = cur.kind;
    assign o_out_byte   = cur.out_byte;
    assign o_arg_index  = cur.arg_index;
    assign o_end_reason = cur.end_reason;
    assign o_last       = cur.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // discarded text never produces a beat
    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_mode == MODE_DISCARD |-> step.n == 2'd0)
        else $error("discard mode produced results");

    // a command end restarts the argument count
    a_cmd_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && step.n != 2'd0 && step.res[step.n - 2'd1].kind == KIND_CMD_END
        |=> r_count == 5'd0)
        else $error("argument count not cleared after command end");

    // the beat flagged last is the only one left in the result register
    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (buf_n == 2'd1)))
        else $error("last flag out of step with result count");

    // a token end that keeps the command open leaves the count below the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && step.next_count != r_count && step.next_count != 5'd0
        |-> step.next_count < limit)
        else $error("argument count reached the limit without command end");

endmodule
